@@ hw/rtl/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and command/status types for the LFU cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int unsigned CAPACITY_DEF   = 16;
	localparam int unsigned COUNT_BITS_DEF = 16;
	localparam int unsigned CFG_W          = 5;
	localparam int unsigned DATA_W         = 32;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic load;
		logic apply;
	} lfu_cmd_t;

	typedef struct packed {
		logic is_get;
	} lfu_sts_t;

endpackage

@@ hw/rtl/lfu_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: take a beat, look up, apply update, present the get result.
// ----------------------------------------------------------------------------
module lfu_ctrl
	import lfu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  lfu_sts_t sts,
	output lfu_cmd_t cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_OUT} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.load  = (state_q == ST_IDLE) && in_valid;
	assign cmd.apply = (state_q == ST_LOOK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (sts.is_get) begin
						state_q     <= ST_OUT;
						out_valid_q <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/lfu_dp.sv @@
// ----------------------------------------------------------------------------
// lfu_dp
// Entry array with parallel key match, victim selection and update.
// ----------------------------------------------------------------------------
module lfu_dp
	import lfu_pkg::*;
#(
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lfu_cmd_t                 cmd,
	output lfu_sts_t                 sts,
	input  logic                     cfg_we,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     action,
	input  logic signed [DATA_W-1:0] key,
	input  logic signed [DATA_W-1:0] write_value,
	output logic                     hit,
	output logic signed [DATA_W-1:0] read_value
);

	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned OW = $clog2(CAPACITY + 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [CFG_W-1:0]      cap_q;
	logic                  valid_q [CAPACITY];
	logic [DATA_W-1:0]     key_q   [CAPACITY];
	logic [DATA_W-1:0]     val_q   [CAPACITY];
	logic [COUNT_BITS-1:0] cnt_q   [CAPACITY];
	logic [IW-1:0]         rank_q  [CAPACITY];
	logic [OW-1:0]         occ_q;

	logic                  act_s1;
	logic [DATA_W-1:0]     key_s1, wval_s1;
	logic [CAPACITY-1:0]   match_s1;
	logic                  hit_s1;
	logic                  hit_q;
	logic [DATA_W-1:0]     rval_q;

	logic [CAPACITY-1:0]   match;
	logic [CAPACITY-1:0]   vict;
	logic [IW-1:0]         hslot, vslot, fslot;
	logic                  vfound, ffound;
	logic [OW:0]           eff_cap;
	logic                  need_evict;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++)
			match[i] = valid_q[i] && (key_q[i] == key);
	end

	always_comb begin
		hslot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--)
			if (match_s1[i]) hslot = IW'(i);
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			vict[i] = valid_q[i];
			for (int j = 0; j < CAPACITY; j++)
				if (j != i && valid_q[j] && !(cnt_q[i] < cnt_q[j] ||
				    (cnt_q[i] == cnt_q[j] && rank_q[i] > rank_q[j])))
					vict[i] = 1'b0;
		end
	end

	always_comb begin
		vslot = '0;
		for (int i = 0; i < CAPACITY; i++)
			if (vict[i]) vslot = IW'(i);
	end

	assign vfound = |vict;

	always_comb begin
		if (cap_q == '0)
			eff_cap = (OW+1)'(1);
		else if (32'(cap_q) > CAPACITY)
			eff_cap = (OW+1)'(CAPACITY);
		else
			eff_cap = (OW+1)'(cap_q);
		need_evict = ((OW+1)'(occ_q) >= eff_cap) && vfound;
	end

	always_comb begin
		fslot  = '0;
		ffound = 1'b0;
		for (int i = CAPACITY - 1; i >= 0; i--)
			if (!valid_q[i] || (need_evict && vslot == IW'(i))) begin
				fslot  = IW'(i);
				ffound = 1'b1;
			end
	end

	assign sts.is_get = (act_s1 == ACT_GET);
	assign hit        = hit_q;
	assign read_value = rval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CFG_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_s1   <= action;
			key_s1   <= key;
			wval_s1  <= write_value;
			match_s1 <= match;
			hit_s1   <= |match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			for (int i = 0; i < CAPACITY; i++) valid_q[i] <= 1'b0;
		end else if (cmd.apply) begin
			if (hit_s1) begin
				for (int i = 0; i < CAPACITY; i++)
					if (valid_q[i] && rank_q[i] < rank_q[hslot]) rank_q[i] <= rank_q[i] + 1'b1;
				rank_q[hslot] <= '0;
				if (cnt_q[hslot] != CNT_MAX) cnt_q[hslot] <= cnt_q[hslot] + 1'b1;
				if (act_s1 == ACT_PUT) val_q[hslot] <= wval_s1;
			end else if (act_s1 == ACT_PUT) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (valid_q[i] && !(need_evict && vslot == IW'(i))) begin
						if (need_evict && rank_q[i] > rank_q[vslot])
							rank_q[i] <= rank_q[i];
						else
							rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
				if (ffound) begin
					if (need_evict && vslot != fslot) valid_q[vslot] <= 1'b0;
					valid_q[fslot] <= 1'b1;
					key_q[fslot]   <= key_s1;
					val_q[fslot]   <= wval_s1;
					cnt_q[fslot]   <= COUNT_BITS'(1);
					rank_q[fslot]  <= '0;
					if (!need_evict) occ_q <= occ_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && act_s1 == ACT_GET) begin
			hit_q  <= hit_s1;
			rval_q <= hit_s1 ? val_q[hslot] : '1;
		end
	end

endmodule

@@ hw/rtl/lfu_cache_lru_tiebreak_unit.sv @@
// Get results are registered at the end of the ST_LOOK state and presented in ST_OUT.
// A new input beat is not taken until the current get or put has finished (in_stall).
// The lookup cycle and the update cycle share one entry array, in sequence.
// Reset: asynchronous active-low; clears valid bits, occupancy and capacity to 16.
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_unit
// LFU key-value cache with LRU tie break.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_unit
	import lfu_pkg::*;
#(
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  logic signed [DATA_W-1:0] key,
	input  logic signed [DATA_W-1:0] write_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic signed [DATA_W-1:0] read_value
);

	lfu_cmd_t cmd;
	lfu_sts_t sts;

	lfu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	lfu_dp #(.CAPACITY(CAPACITY), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .action(action), .key(key),
		.write_value(write_value), .hit(hit), .read_value(read_value)
	);

endmodule

@@ hw/rtl/lfu_checker.sv @@
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks for the LFU cache.
// ----------------------------------------------------------------------------
module lfu_checker
	import lfu_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              hit,
	input logic [DATA_W-1:0] read_value
);

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> read_value == '1) else $error("miss value");

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept while result pending");

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("no busy after accept");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value))
		else $error("result dropped");

endmodule

bind lfu_cache_lru_tiebreak_unit lfu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .hit(hit),
	.read_value(read_value)
);
